FILE: hw/rtl/nfba_pkg.sv
// Package for the next-fit block allocator.
// Holds field widths, command and status codes and parameter defaults.
// No dependencies.
package nfba_pkg;

  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 32;

  localparam int SIZE_W = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

endpackage

FILE: hw/rtl/nfba_req_if.sv
// Request channel of the allocator: valid/ready handshake with command payload.
// Depends on nfba_pkg.
interface nfba_req_if import nfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SIZE_W-1:0] request_size;
  logic [SIZE_W-1:0] block_offset;

  modport source (output valid, command, request_size, block_offset, input ready);
  modport sink   (input valid, command, request_size, block_offset, output ready);
endinterface

FILE: hw/rtl/nfba_rsp_if.sv
// Response channel of the allocator: valid/ready handshake with result payload.
// Depends on nfba_pkg.
interface nfba_rsp_if import nfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [SIZE_W-1:0] payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink   (input valid, status, payload_offset, output ready);
endinterface

FILE: hw/rtl/nfba_hdr_mem.sv
// Single-port header memory with registered read data.
// Entry 0 reads as zero until first written. No dependencies.
module nfba_hdr_mem #(
  parameter int AW = 12,
  parameter int DW = 27
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] q;
  logic          valid0;
  logic          zero_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      if (we && addr == '0) begin
        valid0 <= 1'b1;
      end
      if (re) begin
        zero_q <= (addr == '0) && !valid0;
      end
    end
  end

  assign rdata = zero_q ? '0 : q;

endmodule

FILE: hw/rtl/next_fit_block_allocator_top.sv
// Next-fit block allocator with coalescing: top level with control sequencer.
// Depends on nfba_pkg, nfba_req_if, nfba_rsp_if and nfba_hdr_mem.
//
// The arena is a chain of block headers kept in one single-port memory with
// registered read data. An allocate is accepted, then reads and checks each
// block visited during the search (A_RD, A_EV), restarting at the head when
// the search wraps, then splits the block (A_WNB, A_WB, then A_RN and A_WN
// to fix the next block's back link) and posts the result, so its time grows
// with the number of blocks in the chain. A free merges free neighbours and
// posts the result. One request is handled at a time; the next one is taken
// while the previous result still waits on the response channel.
module next_fit_block_allocator_top import nfba_pkg::*; #(
  parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  nfba_req_if.sink    req,
  nfba_rsp_if.source  rsp
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int CW = ((AW + 1 > SIZE_W + 1) ? AW + 1 : SIZE_W + 1) + 2;
  localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
  localparam logic [AW:0]   STEP_LIM = (AW + 1)'(ARENA_BYTES + 1);

  typedef struct packed {
    logic [AW-1:0] next;
    logic [AW-1:0] prev;
    logic          has_next;
    logic          has_prev;
    logic          used;
  } hdr_t;

  localparam int DW = $bits(hdr_t);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] A_RD   = 5'd1;
  localparam logic [4:0] A_EV   = 5'd2;
  localparam logic [4:0] A_WNB  = 5'd3;
  localparam logic [4:0] A_WB   = 5'd4;
  localparam logic [4:0] A_RN   = 5'd5;
  localparam logic [4:0] A_WN   = 5'd6;
  localparam logic [4:0] F_RH   = 5'd7;
  localparam logic [4:0] F_WH   = 5'd8;
  localparam logic [4:0] F_RP   = 5'd9;
  localparam logic [4:0] F_CP   = 5'd10;
  localparam logic [4:0] F_RN   = 5'd11;
  localparam logic [4:0] F_CN   = 5'd12;
  localparam logic [4:0] F_RK   = 5'd13;
  localparam logic [4:0] F_WK   = 5'd14;
  localparam logic [4:0] F_RX   = 5'd15;
  localparam logic [4:0] F_WX   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]        state;
  logic [AW-1:0]     blk;
  logic [AW-1:0]     start;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     keep;
  logic [AW-1:0]     nx;
  logic              hnx;
  logic              phase;
  logic [AW:0]       cnt;
  logic [SIZE_W-1:0] req_size;
  hdr_t              hdr;
  logic              res_status;
  logic [SIZE_W-1:0] res_off;

  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] mem_rdata;
  hdr_t          rd;
  hdr_t          wr;

  logic [CW-1:0] end_v;
  logic [CW-1:0] diff;
  logic [CW-1:0] need;
  logic [CW-1:0] nb_sum;
  logic [CW-1:0] pay_sum;
  logic [CW-1:0] off_h;
  logic          fits;
  logic          free_ok;
  logic [AW-1:0] nb;

  nfba_hdr_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign rd      = hdr_t'(mem_rdata);
  assign end_v   = rd.has_next ? CW'(rd.next) : ARENA_C;
  assign diff    = end_v - (CW'(blk) + HDR_C);
  assign need    = CW'(req_size) + HDR_C;
  assign fits    = !rd.used && ($signed(diff) >= $signed(need));
  assign nb_sum  = CW'(blk) + HDR_C + CW'(req_size);
  assign nb      = nb_sum[AW-1:0];
  assign pay_sum = CW'(blk) + HDR_C;
  assign off_h   = CW'(req.block_offset) - HDR_C;
  assign free_ok = (CW'(req.block_offset) >= HDR_C) && (off_h < ARENA_C);

  assign req.ready = (state == S_IDLE);

  always_comb begin
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = blk;
    wr       = hdr;
    unique case (state)
      A_RD: begin
        mem_re = 1'b1;
      end
      A_WNB: begin
        mem_we      = 1'b1;
        mem_addr    = nb;
        wr.next     = hdr.next;
        wr.has_next = hdr.has_next;
        wr.prev     = blk;
        wr.has_prev = 1'b1;
        wr.used     = 1'b0;
      end
      A_WB: begin
        mem_we      = 1'b1;
        wr.next     = nb;
        wr.has_next = 1'b1;
        wr.used     = 1'b1;
      end
      A_RN: begin
        mem_re   = 1'b1;
        mem_addr = hdr.next;
      end
      A_WN: begin
        mem_we      = 1'b1;
        mem_addr    = hdr.next;
        wr          = rd;
        wr.prev     = nb;
        wr.has_prev = 1'b1;
      end
      F_RH: begin
        mem_re = 1'b1;
      end
      F_WH: begin
        mem_we  = 1'b1;
        wr      = rd;
        wr.used = 1'b0;
      end
      F_RP: begin
        mem_re   = hdr.has_prev;
        mem_addr = hdr.prev;
      end
      F_RN: begin
        mem_re   = hdr.has_next;
        mem_addr = hdr.next;
      end
      F_RK: begin
        mem_re   = 1'b1;
        mem_addr = keep;
      end
      F_WK: begin
        mem_we      = 1'b1;
        mem_addr    = keep;
        wr          = rd;
        wr.next     = nx;
        wr.has_next = hnx;
      end
      F_RX: begin
        mem_re   = 1'b1;
        mem_addr = nx;
      end
      F_WX: begin
        mem_we      = 1'b1;
        mem_addr    = nx;
        wr          = rd;
        wr.prev     = keep;
        wr.has_prev = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mem_wdata = DW'(wr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_size   <= req.request_size;
            res_status <= STATUS_DONE;
            res_off    <= '0;
            if (req.command == CMD_ALLOC) begin
              blk   <= cur;
              start <= cur;
              phase <= 1'b0;
              cnt   <= '0;
              state <= A_RD;
            end else if (free_ok) begin
              blk   <= off_h[AW-1:0];
              state <= F_RH;
            end else begin
              state <= S_DONE;
            end
          end
        end
        A_RD: begin
          if (cnt == STEP_LIM || (phase && blk == start)) begin
            if (phase) begin
              res_status <= STATUS_NOFIT;
              state      <= S_DONE;
            end else begin
              phase <= 1'b1;
              blk   <= '0;
              cnt   <= '0;
            end
          end else begin
            state <= A_EV;
          end
        end
        A_EV: begin
          if (fits) begin
            hdr   <= rd;
            state <= A_WNB;
          end else if (!rd.has_next) begin
            if (phase) begin
              res_status <= STATUS_NOFIT;
              state      <= S_DONE;
            end else begin
              phase <= 1'b1;
              blk   <= '0;
              cnt   <= '0;
              state <= A_RD;
            end
          end else begin
            blk   <= rd.next;
            cnt   <= cnt + 1'b1;
            state <= A_RD;
          end
        end
        A_WNB: begin
          state <= A_WB;
        end
        A_WB: begin
          cur     <= blk;
          res_off <= pay_sum[SIZE_W-1:0];
          state   <= hdr.has_next ? A_RN : S_DONE;
        end
        A_RN: begin
          state <= A_WN;
        end
        A_WN: begin
          state <= S_DONE;
        end
        F_RH: begin
          state <= F_WH;
        end
        F_WH: begin
          hdr   <= rd;
          state <= F_RP;
        end
        F_RP: begin
          keep  <= blk;
          state <= hdr.has_prev ? F_CP : F_RN;
        end
        F_CP: begin
          if (!rd.used) begin
            keep <= hdr.prev;
          end
          state <= F_RN;
        end
        F_RN: begin
          nx  <= hdr.next;
          hnx <= 1'b0;
          state <= hdr.has_next ? F_CN : F_RK;
        end
        F_CN: begin
          if (!rd.used) begin
            nx  <= rd.next;
            hnx <= rd.has_next;
          end else begin
            hnx <= 1'b1;
          end
          state <= F_RK;
        end
        F_RK: begin
          state <= F_WK;
        end
        F_WK: begin
          cur   <= keep;
          state <= hnx ? F_RX : S_DONE;
        end
        F_RX: begin
          state <= F_WX;
        end
        F_WX: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.status         <= res_status;
            rsp.payload_offset <= res_off;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/next_fit_block_allocator_top_test.sv
// Testbench for next_fit_block_allocator_top: random and directed alloc/free traffic,
// with results checked against a behavioral next-fit heap kept in this module.
// Depends on nfba_pkg, nfba_req_if, nfba_rsp_if and the allocator RTL.
`timescale 1ns / 100ps

module next_fit_block_allocator_top_test;
  import nfba_pkg::*;

  localparam int ARENA  = ARENA_BYTES_DEF;
  localparam int HDR    = HEADER_BYTES_DEF;
  localparam int NITEMS = 550;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [SIZE_W-1:0] block_offset;
  } heap_cmd_t;

  typedef struct packed {
    logic              status;
    logic [SIZE_W-1:0] payload_offset;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nfba_req_if req_ch ();
  nfba_rsp_if rsp_ch ();

  next_fit_block_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  // Shadow heap
  int unsigned hdr_next [ARENA];
  int unsigned hdr_prev [ARENA];
  bit          hdr_has_next [ARENA];
  bit          hdr_has_prev [ARENA];
  bit          hdr_used [ARENA];
  bit          hdr_written [ARENA];
  int unsigned cur_block;

  heap_cmd_t cmd_q [$];
  heap_rsp_t expected_rsp_q [$];
  int unsigned live_offsets [$];
  int errors = 0;
  int rsp_seen = 0;
  bit stim_done = 1'b0;

  function automatic bit block_fits(int unsigned b, longint need);
    longint stop;
    stop = hdr_has_next[b] ? longint'(hdr_next[b]) : longint'(ARENA);
    return !hdr_used[b] && (stop - longint'(b) - HDR) >= need;
  endfunction

  function automatic bit find_block(longint need, output int unsigned found);
    int unsigned b;
    bit alive;
    int steps;
    b = cur_block;
    alive = 1'b1;
    found = 0;
    for (steps = 0; alive && steps <= ARENA; steps++) begin
      if (block_fits(b, need)) begin
        found = b;
        return 1'b1;
      end
      alive = hdr_has_next[b];
      b = hdr_next[b];
    end
    b = 0;
    alive = 1'b1;
    for (steps = 0; alive && b != cur_block && steps <= ARENA; steps++) begin
      if (block_fits(b, need)) begin
        found = b;
        return 1'b1;
      end
      alive = hdr_has_next[b];
      b = hdr_next[b];
    end
    return 1'b0;
  endfunction

  function automatic heap_rsp_t apply_heap_cmd(heap_cmd_t c);
    heap_rsp_t r;
    int unsigned b, nb, n, h, keep, nx;
    bit hn, hnx;
    r.status = STATUS_DONE;
    r.payload_offset = '0;
    if (c.command == CMD_ALLOC) begin
      if (!find_block(longint'(c.request_size) + HDR, b)) begin
        r.status = STATUS_NOFIT;
        return r;
      end
      nb = b + HDR + c.request_size;
      n = hdr_next[b];
      hn = hdr_has_next[b];
      hdr_next[nb] = n;
      hdr_has_next[nb] = hn;
      hdr_prev[nb] = b;
      hdr_has_prev[nb] = 1'b1;
      hdr_used[nb] = 1'b0;
      hdr_written[nb] = 1'b1;
      hdr_next[b] = nb;
      hdr_has_next[b] = 1'b1;
      hdr_used[b] = 1'b1;
      if (hn) begin
        hdr_prev[n] = nb;
        hdr_has_prev[n] = 1'b1;
      end
      cur_block = b;
      r.payload_offset = SIZE_W'(b + HDR);
    end else begin
      if (c.block_offset < HDR) return r;
      h = c.block_offset - HDR;
      if (h >= ARENA) return r;
      hdr_used[h] = 1'b0;
      keep = h;
      if (hdr_has_prev[h] && !hdr_used[hdr_prev[h]]) keep = hdr_prev[h];
      nx = hdr_next[h];
      hnx = hdr_has_next[h];
      if (hnx && !hdr_used[nx]) begin
        hnx = hdr_has_next[nx];
        nx = hdr_next[nx];
      end
      hdr_next[keep] = nx;
      hdr_has_next[keep] = hnx;
      if (hnx) begin
        hdr_prev[nx] = keep;
        hdr_has_prev[nx] = 1'b1;
      end
      cur_block = keep;
    end
    return r;
  endfunction

  task automatic issue(logic command, int unsigned size, int unsigned offset);
    heap_cmd_t c;
    heap_rsp_t r;
    int idx;
    c.command = command;
    c.request_size = SIZE_W'(size);
    c.block_offset = SIZE_W'(offset);
    r = apply_heap_cmd(c);
    if (command == CMD_ALLOC && r.status == STATUS_DONE) live_offsets.push_back(r.payload_offset);
    if (command == CMD_FREE) begin
      for (idx = 0; idx < live_offsets.size(); idx++)
        if (live_offsets[idx] == offset) begin
          live_offsets.delete(idx);
          break;
        end
    end
    cmd_q.push_back(c);
    expected_rsp_q.push_back(r);
  endtask

  function automatic int unsigned pick_written_offset();
    int unsigned h;
    do h = $urandom_range(0, ARENA - HDR - 1); while (!hdr_written[h]);
    return h + HDR;
  endfunction

  // Stimulus
  initial begin
    int unsigned sel, size, k;
    for (int i = 0; i < ARENA; i++) begin
      hdr_next[i] = 0;
      hdr_prev[i] = 0;
      hdr_has_next[i] = 0;
      hdr_has_prev[i] = 0;
      hdr_used[i] = 0;
      hdr_written[i] = 0;
    end
    hdr_written[0] = 1'b1;
    cur_block = 0;

    issue(CMD_ALLOC, 100, $urandom_range(0, 4095));
    issue(CMD_ALLOC, 200, 4095);
    issue(CMD_ALLOC, 4095, 0);
    issue(CMD_ALLOC, 50, 2048);
    issue(CMD_FREE, 0, 32);
    issue(CMD_ALLOC, 68, 0);
    issue(CMD_FREE, 0, 5);
    issue(CMD_FREE, 0, 0);
    issue(CMD_FREE, 0, 31);
    issue(CMD_FREE, 4095, 164);
    issue(CMD_ALLOC, 0, 0);
    issue(CMD_FREE, 0, 164);
    issue(CMD_FREE, 0, 32);
    issue(CMD_FREE, 0, 396);
    issue(CMD_ALLOC, 4000, 1234);
    issue(CMD_FREE, 0, 32);
    issue(CMD_ALLOC, ARENA - 2 * HDR, 0);
    issue(CMD_FREE, 0, 32);
    issue(CMD_ALLOC, 2047, 2730);
    issue(CMD_ALLOC, 1365, 1365);

    for (int n = 0; n < NITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        issue(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, HDR - 1));
      end else if (sel < 12) begin
        issue(CMD_FREE, $urandom_range(0, 4095), pick_written_offset());
      end else if (live_offsets.size() > 0 &&
                   (sel < 45 || live_offsets.size() > 24)) begin
        k = $urandom_range(0, live_offsets.size() - 1);
        issue(CMD_FREE, $urandom_range(0, 4095), live_offsets[k]);
      end else begin
        k = $urandom_range(0, 9);
        if (k < 7) size = $urandom_range(0, 255);
        else if (k < 9) size = $urandom_range(256, 1023);
        else size = $urandom_range(1024, 4095);
        issue(CMD_ALLOC, size, $urandom_range(0, 4095));
      end
    end
    stim_done = 1'b1;
  end

  // Request driver
  int req_gap;
  bit req_burst;
  always @(posedge clk) begin
    heap_cmd_t c;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_ALLOC;
      req_ch.request_size <= '0;
      req_ch.block_offset <= '0;
      req_gap <= 0;
      req_burst <= 1'b0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold
    end else if (req_gap > 0) begin
      req_ch.valid <= 1'b0;
      req_gap <= req_gap - 1;
    end else if (cmd_q.size() > 0) begin
      c = cmd_q.pop_front();
      req_ch.valid <= 1'b1;
      req_ch.command <= c.command;
      req_ch.request_size <= c.request_size;
      req_ch.block_offset <= c.block_offset;
      if ($urandom_range(0, 29) == 0) req_burst <= ~req_burst;
      req_gap <= req_burst ? 0 : $urandom_range(0, 19);
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Response monitor
  int rsp_stall;
  bit pressure_done;
  always @(posedge clk) begin
    heap_rsp_t e;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= 0;
      pressure_done <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen <= rsp_seen + 1;
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response status=%0d payload_offset=%0d",
                 rsp_ch.status, rsp_ch.payload_offset);
          errors++;
        end else begin
          e = expected_rsp_q.pop_front();
          if (rsp_ch.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.payload_offset !== e.payload_offset) begin
            $error("payload_offset expected %0d actual %0d",
                   e.payload_offset, rsp_ch.payload_offset);
            errors++;
          end
        end
      end
      if (!pressure_done && rsp_seen == 150) begin
        pressure_done <= 1'b1;
        rsp_ch.ready <= 1'b0;
        rsp_stall <= 600;
      end else if (rsp_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_stall <= rsp_stall - 1;
      end else if (rsp_ch.valid && rsp_ch.ready || !rsp_ch.ready) begin
        if (rsp_ch.valid && rsp_ch.ready && !req_burst) begin
          rsp_ch.ready <= 1'b0;
          rsp_stall <= $urandom_range(0, 19);
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    wait (cmd_q.size() == 0 && expected_rsp_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/nfba_pkg.sv
hw/rtl/nfba_req_if.sv
hw/rtl/nfba_rsp_if.sv
hw/rtl/nfba_hdr_mem.sv
hw/rtl/next_fit_block_allocator_top.sv
bench/next_fit_block_allocator_top_test.sv
